// ===== src/gtc_pkg.sv =====
`timescale 1ns / 1ps

package gtc_pkg;

  // Graph size and field widths
  localparam int MaxVertices = 16;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);
  localparam int ColorW      = 2;
  localparam int PaddrW      = 3;
  localparam int PdataW      = 32;

  // Color codes
  localparam logic [ColorW-1:0] Color0  = 2'd0;
  localparam logic [ColorW-1:0] Color1  = 2'd1;
  localparam logic [ColorW-1:0] Color2  = 2'd2;
  localparam logic [ColorW-1:0] NoColor = 2'd3;

  // Command opcodes
  localparam logic OpAddEdge = 1'b0;
  localparam logic OpRun     = 1'b1;

  // Register index (paddr[2])
  localparam logic RegVertexCount = 1'b0;

  localparam logic [CntW-1:0] VertexCountReset = CntW'(4);

  // Input word
  typedef struct packed {
    logic            opcode;
    logic [VtxW-1:0] src;
    logic [VtxW-1:0] dest;
  } gtc_in_t;

  // Result word
  typedef struct packed {
    logic [VtxW-1:0]   vertex;
    logic [ColorW-1:0] color;
    logic              colorable;
    logic              last;
  } gtc_out_t;

  // Edge write request into the adjacency matrix
  typedef struct packed {
    logic            we;
    logic [VtxW-1:0] src;
    logic [VtxW-1:0] dest;
  } gtc_edge_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } gtc_state_e;

endpackage

// ===== src/greedy_three_coloring_core.sv =====
`timescale 1ns / 1ps

// Greedy three-coloring core.
// Command channel: a word (opcode, src, dest) is taken when start_i is high
// and busy_o is low. Opcode add-edge stores an undirected edge and leaves
// busy_o low, so edges can be loaded every cycle.
// Opcode run colors vertices 0..n-1 (n = vertex_count) in order and then
// emits n result words, one per cycle, each marked by result_valid_o for a
// single cycle; the receiver cannot stall them. last is set on vertex n-1.
// A run walks every lower-numbered vertex of every vertex through one shared
// check unit, one lower vertex per cycle, and then emits the results.
// busy_o stays high through the scan and the emit, and the next command can be
// taken in the cycle after the last result.
// Config: APB register vertex_count at address 0 (clamped to 1..16, reset 4).
// Reset clears all edges, sets vertex_count to 4 and returns to idle.
// Edges persist across runs; only reset removes them.
module greedy_three_coloring_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gtc_pkg::PaddrW-1:0] paddr,
  input  logic [gtc_pkg::PdataW-1:0] pwdata,
  output logic [gtc_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  input  logic                       start_i,
  input  gtc_pkg::gtc_in_t           cmd_i,
  output logic                       busy_o,
  output logic                       result_valid_o,
  output gtc_pkg::gtc_out_t          result_o
);
  import gtc_pkg::*;

  logic [CntW-1:0]        vcount_q, vcount_d;
  logic                   cfg_wr;
  logic                   accept;
  gtc_edge_t              edge_req;
  logic [VtxW-1:0]        row_sel;
  logic [MaxVertices-1:0] adj_row;

  // Config register with clamp on write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegVertexCount);

  always_comb begin
    vcount_d = vcount_q;
    if (cfg_wr) begin
      if (pwdata[CntW-1:0] == '0) begin
        vcount_d = CntW'(1);
      end else if (pwdata[CntW-1:0] > CntW'(MaxVertices)) begin
        vcount_d = CntW'(MaxVertices);
      end else begin
        vcount_d = pwdata[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountReset;
    end else begin
      vcount_q <= vcount_d;
    end
  end

  assign prdata = (paddr[2] == RegVertexCount) ?
                  {{(PdataW-CntW){1'b0}}, vcount_q} : '0;

  // Command decode
  assign accept        = start_i && !busy_o;
  assign edge_req.we   = accept && (cmd_i.opcode == OpAddEdge);
  assign edge_req.src  = cmd_i.src;
  assign edge_req.dest = cmd_i.dest;

  gtc_adj u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .edge_i    (edge_req),
    .row_sel_i (row_sel),
    .row_o     (adj_row)
  );

  gtc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_i          (accept && (cmd_i.opcode == OpRun)),
    .vertex_count_i (vcount_q),
    .adj_row_i      (adj_row),
    .row_sel_o      (row_sel),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== src/gtc_adj.sv =====
`timescale 1ns / 1ps

module gtc_adj (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gtc_pkg::gtc_edge_t              edge_i,
  input  logic [gtc_pkg::VtxW-1:0]        row_sel_i,
  output logic [gtc_pkg::MaxVertices-1:0] row_o
);
  import gtc_pkg::*;

  logic [MaxVertices-1:0] adj_q [MaxVertices];

  // Edge write sets both directions; bits only ever get set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxVertices; r++) begin
        adj_q[r] <= '0;
      end
    end else if (edge_i.we) begin
      adj_q[edge_i.src][edge_i.dest] <= 1'b1;
      adj_q[edge_i.dest][edge_i.src] <= 1'b1;
    end
  end

  // Single row read for the scan
  assign row_o = adj_q[row_sel_i];

endmodule

// ===== src/gtc_ctrl.sv =====
`timescale 1ns / 1ps

module gtc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            run_i,
  input  logic [gtc_pkg::CntW-1:0]        vertex_count_i,
  input  logic [gtc_pkg::MaxVertices-1:0] adj_row_i,
  output logic [gtc_pkg::VtxW-1:0]        row_sel_o,
  output logic                            busy_o,
  output logic                            result_valid_o,
  output gtc_pkg::gtc_out_t               result_o
);
  import gtc_pkg::*;

  gtc_state_e        state_q, state_d;
  logic [VtxW-1:0]   u_q, u_d;
  logic [VtxW-1:0]   w_q, w_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [2:0]        used_q, used_d;
  logic              ok_q, ok_d;

  // Color store, no reset: a run writes each entry before reading it
  logic [ColorW-1:0] col_q [MaxVertices];
  logic              col_we;
  logic [VtxW-1:0]   col_waddr;
  logic [ColorW-1:0] col_wdata;
  logic [VtxW-1:0]   col_raddr;
  logic [ColorW-1:0] col_rdata;

  logic              u_is_last;
  logic              w_is_last;
  logic              hit;
  logic [2:0]        used_next;
  logic [ColorW-1:0] pick;

  assign col_raddr = (state_q == StEmit) ? u_q : w_q;
  assign col_rdata = col_q[col_raddr];
  assign row_sel_o = u_q;

  assign u_is_last = ({1'b0, u_q} == (n_q - CntW'(1)));
  assign w_is_last = (w_q == (u_q - VtxW'(1)));

  // Shared check unit: one lower vertex per cycle
  always_comb begin
    hit       = adj_row_i[w_q] && (col_rdata != NoColor);
    used_next = used_q;
    if (hit) begin
      used_next = used_q | (3'b001 << col_rdata);
    end
    if (!used_next[0]) begin
      pick = Color0;
    end else if (!used_next[1]) begin
      pick = Color1;
    end else if (!used_next[2]) begin
      pick = Color2;
    end else begin
      pick = NoColor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      u_q     <= '0;
      w_q     <= '0;
      n_q     <= VertexCountReset;
      used_q  <= '0;
      ok_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      u_q     <= u_d;
      w_q     <= w_d;
      n_q     <= n_d;
      used_q  <= used_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_q[col_waddr] <= col_wdata;
    end
  end

  // Sequencer: scan lower-numbered vertices of each vertex, then emit colors
  always_comb begin
    state_d   = state_q;
    u_d       = u_q;
    w_d       = w_q;
    n_d       = n_q;
    used_d    = used_q;
    ok_d      = ok_q;
    col_we    = 1'b0;
    col_waddr = u_q;
    col_wdata = pick;
    case (state_q)
      StIdle: begin
        if (run_i) begin
          n_d       = vertex_count_i;
          ok_d      = 1'b1;
          used_d    = '0;
          w_d       = '0;
          col_we    = 1'b1;
          col_waddr = '0;
          col_wdata = Color0;
          if (vertex_count_i == CntW'(1)) begin
            u_d     = '0;
            state_d = StEmit;
          end else begin
            u_d     = VtxW'(1);
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (w_is_last) begin
          col_we = 1'b1;
          if (pick == NoColor) begin
            ok_d = 1'b0;
          end
          used_d = '0;
          w_d    = '0;
          if (u_is_last) begin
            u_d     = '0;
            state_d = StEmit;
          end else begin
            u_d = u_q + VtxW'(1);
          end
        end else begin
          used_d = used_next;
          w_d    = w_q + VtxW'(1);
        end
      end
      StEmit: begin
        if (u_is_last) begin
          u_d     = '0;
          state_d = StIdle;
        end else begin
          u_d = u_q + VtxW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result word straight from the sequencer registers
  assign busy_o             = (state_q != StIdle);
  assign result_valid_o     = (state_q == StEmit);
  assign result_o.vertex    = u_q;
  assign result_o.color     = col_rdata;
  assign result_o.colorable = ok_q;
  assign result_o.last      = u_is_last;

endmodule
